// ===== rtl/first_fit_region_allocator_assert.svh =====
// Assertion macros for the first-fit region allocator.
// Depends on nothing; included by the top level.
`ifndef FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FFRA_ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("assertion failed");
`define FFRA_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("assertion failed");
`endif

// ===== rtl/ffra_pkg.sv =====
// Package for the first-fit region allocator: commands, status codes, states.
// Depends on nothing.
package ffra_pkg;
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OOM       = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_ZERO      = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SCAN, S_SHIFT, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE, OP_INSERT, OP_ERASE
  } op_t;

  typedef struct packed {
    logic start;
    logic rd;
    logic step;
    logic shift;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic scan_end;
    logic hit;
    logic shift_end;
    op_t  op;
  } stat_t;
endpackage

// ===== rtl/ffra_if.sv =====
// Valid/ready request channel carrying a parameterized payload.
// Depends on nothing.
interface ffra_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ffra_ctrl.sv =====
// Controller state machine of the allocator.
// Depends on ffra_pkg.
module ffra_ctrl import ffra_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output ctrl_t ctl
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.start = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (st.scan_end) begin
          state_next = (st.op == OP_NONE) ? S_DONE : S_SHIFT;
          ctl.finish = 1'b1;
        end else begin
          ctl.rd = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.step = 1'b1;
        state_next = st.hit ? S_DONE : S_READ;
        if (st.hit) begin
          ctl.finish = 1'b1;
          if (st.op != OP_NONE) state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        ctl.shift = 1'b1;
        if (st.shift_end) state_next = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/ffra_dp.sv =====
// Datapath: block table memories, scan registers, insert and erase shifting.
// Depends on ffra_pkg.
module ffra_dp import ffra_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          region_size,
  input  logic [1:0]           cmd,
  input  logic [31:0]          req_size,
  input  logic [31:0]          req_offset,
  input  ctrl_t                ctl,
  output stat_t                st,
  output logic [2:0]           status,
  output logic [31:0]          grant_offset,
  output logic                 is_live,
  output logic [31:0]          bytes_in_use
);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  logic [ADDR_BITS-1:0] offs [MAX_BLOCKS];
  logic [ADDR_BITS-1:0] sizes [MAX_BLOCKS];
  logic [ADDR_BITS-1:0] rd_off, rd_size, sh_off, sh_size;

  logic [CW-1:0] live_count, pos, sh_idx;
  logic [ADDR_BITS-1:0] cur, size_r, key, region;
  logic [1:0] cmd_r;
  logic [2:0] status_r;
  logic live_r, hit_r, rd_valid;
  logic [31:0] used;
  op_t op;
  logic [IW-1:0] sh_src, sh_dst;
  logic sh_phase;

  assign region = ADDR_BITS'(region_size);

  logic fits, key_eq;
  assign fits = (rd_off >= cur) && ((rd_off - cur) >= size_r);
  assign key_eq = (rd_off == key);
  logic scan_hit;
  assign scan_hit = (cmd_r == CMD_ALLOC) ? fits : key_eq;

  logic oom;
  assign oom = (size_r > region) || (cur > region - size_r);

  assign st.scan_end = (pos == live_count) || (cmd_r != CMD_ALLOC && cmd_r != CMD_FREE
                        && cmd_r != CMD_QUERY) || status_r != ST_OK || hit_r;
  assign st.hit = scan_hit;
  assign st.shift_end = sh_phase && (sh_idx == pos);

  // Decision made when the scan ends or hits.
  op_t op_dec;
  always_comb begin
    op_dec = OP_NONE;
    if (status_r == ST_OK && !hit_r) begin
      if (cmd_r == CMD_ALLOC && !oom) op_dec = OP_INSERT;
      if (cmd_r == CMD_FREE && rd_valid && key_eq) op_dec = OP_ERASE;
    end
  end
  assign st.op = op_dec;
  assign sh_src = (op == OP_INSERT) ? IW'(sh_idx - CW'(1)) : IW'(sh_idx + CW'(1));
  assign sh_dst = IW'(sh_idx);

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_off <= offs[IW'(pos)];
      rd_size <= sizes[IW'(pos)];
    end
    if (ctl.shift && !sh_phase) begin
      sh_off <= offs[sh_src];
      sh_size <= sizes[sh_src];
    end
    if (ctl.shift && sh_phase) begin
      if (sh_idx == pos && op == OP_INSERT) begin
        offs[sh_dst] <= cur;
        sizes[sh_dst] <= size_r;
      end else if (sh_idx != pos || op == OP_ERASE) begin
        offs[sh_dst] <= sh_off;
        sizes[sh_dst] <= sh_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      used <= '0;
      op <= OP_NONE;
      sh_phase <= 1'b0;
      hit_r <= 1'b0;
      rd_valid <= 1'b0;
      pos <= '0;
      sh_idx <= '0;
      cmd_r <= CMD_ALLOC;
      status_r <= ST_OK;
      live_r <= 1'b0;
      cur <= '0;
    end else begin
      rd_valid <= ctl.rd;
      if (ctl.start) begin
        cmd_r <= cmd;
        size_r <= ADDR_BITS'(req_size);
        key <= ADDR_BITS'(req_offset);
        cur <= '0;
        pos <= '0;
        hit_r <= 1'b0;
        live_r <= 1'b0;
        op <= OP_NONE;
        sh_phase <= 1'b0;
        status_r <= ST_OK;
        if (cmd == CMD_ALLOC && req_size == '0) status_r <= ST_ZERO;
        else if (cmd == CMD_ALLOC && live_count == CW'(MAX_BLOCKS)) status_r <= ST_FULL;
      end
      if (ctl.step && !scan_hit) begin
        cur <= rd_off + rd_size;
        pos <= pos + CW'(1);
      end
      if (ctl.step && scan_hit) hit_r <= 1'b1;
      if (ctl.finish) begin
        op <= op_dec;
        if (cmd_r == CMD_ALLOC && status_r == ST_OK && oom) status_r <= ST_OOM;
        if (cmd_r == CMD_FREE && !(ctl.step && key_eq)) status_r <= ST_NOT_FOUND;
        if (cmd_r == CMD_QUERY) live_r <= ctl.step && key_eq;
        if (op_dec == OP_INSERT) begin
          sh_idx <= live_count;
          live_count <= live_count + CW'(1);
          used <= used + 32'(size_r);
        end
        if (op_dec == OP_ERASE) begin
          sh_idx <= pos;
          live_count <= live_count - CW'(1);
          used <= used - 32'(rd_size);
        end
      end
      if (ctl.shift) begin
        sh_phase <= ~sh_phase;
        if (sh_phase) begin
          if (op == OP_INSERT) sh_idx <= sh_idx - CW'(1);
          else sh_idx <= sh_idx + CW'(1);
        end
      end
      if (op == OP_ERASE && ctl.shift && !sh_phase && sh_idx + CW'(1) >= live_count + CW'(1))
        begin
        sh_phase <= 1'b0;
        op <= OP_NONE;
      end
      if (op == OP_ERASE && ctl.shift && !sh_phase && sh_idx + CW'(1) < live_count + CW'(1))
        pos <= live_count;
    end
  end

  assign status = status_r;
  assign grant_offset = (cmd_r == CMD_ALLOC && status_r == ST_OK) ? 32'(cur) : 32'd0;
  assign is_live = live_r;
  assign bytes_in_use = used;
endmodule

// ===== rtl/first_fit_region_allocator.sv =====
// First-fit region allocator with a sorted block table.
// Each request reads the table entries in order until the scan stops on an entry or
// runs past the last one; an allocate then inserts an entry and a free erases one by
// moving the entries after it. One request is in flight and the next is taken in the
// cycle after the response is accepted. Reset clears the block and byte counts and loads
// region_size with 65536; table contents stay unknown. Needs the package, interface,
// controller, datapath and assertion header.
module first_fit_region_allocator import ffra_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  ffra_if.sink        req,
  ffra_if.source      rsp
);
`include "first_fit_region_allocator_assert.svh"
  logic [31:0] region_size;
  ctrl_t ctl;
  stat_t st;
  logic [2:0] status;
  logic [31:0] grant_offset, bytes_in_use;
  logic is_live;

  always_ff @(posedge clk) begin
    if (rst) region_size <= 32'd65536;
    else if (cfg_we) region_size <= cfg_wdata;
  end

  ffra_ctrl u_ctrl (
    .clk, .rst, .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .st, .ctl
  );

  ffra_dp #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst, .region_size, .cmd(req.data[65:64]), .req_size(req.data[63:32]),
    .req_offset(req.data[31:0]), .ctl, .st, .status, .grant_offset, .is_live,
    .bytes_in_use
  );

  assign rsp.data = {status, grant_offset, is_live, bytes_in_use};

  `FFRA_ASSERT_IMPL(a_excl, req.ready, !rsp.valid)
  `FFRA_ASSERT_NEXT(a_start, req.valid && req.ready, !req.ready)
  `FFRA_ASSERT_IMPL(a_code, rsp.valid, rsp.data[67:65] <= ST_ZERO)
endmodule

// ===== tb/tb_first_fit_region_allocator.sv =====
// Testbench for first_fit_region_allocator: drives allocate, free, query and invalid-command
// requests and checks every response against a behavioral block-table tracker.
// Depends on ffra_pkg, ffra_if and the RTL top level.
module tb_first_fit_region_allocator;
  import ffra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] grant;
    logic        live;
    logic [31:0] used;
  } alloc_reply_t;

  class region_tracker;
    logic [31:0] region;
    logic [31:0] offs[64];
    logic [31:0] sizes[64];
    int unsigned count;
    logic [31:0] used;
    alloc_reply_t pending[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned status_seen[5];

    function new();
      region = 32'd65536;
      count = 0;
      used = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function int find(logic [31:0] off);
      for (int i = 0; i < count; i++) begin
        if (offs[i] == off) return i;
      end
      return -1;
    endfunction

    function void note_request(logic [1:0] cmd, logic [31:0] size, logic [31:0] off);
      alloc_reply_t r;
      logic [31:0] cur;
      int pos;
      int idx;
      r = '0;
      r.status = ST_OK;
      if (cmd == CMD_ALLOC) begin
        if (size == 0) begin
          r.status = ST_ZERO;
        end else if (count >= 64) begin
          r.status = ST_FULL;
        end else begin
          cur = '0;
          pos = 0;
          for (; pos < count; pos++) begin
            if (offs[pos] >= cur && offs[pos] - cur >= size) break;
            cur = offs[pos] + sizes[pos];
          end
          if (size > region || cur > region - size) begin
            r.status = ST_OOM;
          end else begin
            for (int j = count; j > pos; j--) begin
              offs[j] = offs[j-1];
              sizes[j] = sizes[j-1];
            end
            offs[pos] = cur;
            sizes[pos] = size;
            count++;
            used = used + size;
            r.grant = cur;
          end
        end
      end else if (cmd == CMD_FREE) begin
        idx = find(off);
        if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          used = used - sizes[idx];
          for (int j = idx; j + 1 < count; j++) begin
            offs[j] = offs[j+1];
            sizes[j] = sizes[j+1];
          end
          count--;
        end
      end else if (cmd == CMD_QUERY) begin
        r.live = (find(off) >= 0);
      end
      r.used = used;
      pending.push_back(r);
    endfunction

    function void check_result(alloc_reply_t got);
      alloc_reply_t exp;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected response %h", got);
        return;
      end
      exp = pending.pop_front();
      if (exp.status <= ST_ZERO) status_seen[exp.status]++;
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: status %0d/%0d grant %h/%h live %0d/%0d used %h/%h (exp/act)",
                   exp.status, got.status, exp.grant, got.grant, exp.live, got.live,
                   exp.used, got.used);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  ffra_if #(66) req_if ();
  ffra_if #(68) rsp_if ();

  first_fit_region_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req_if), .rsp(rsp_if)
  );

  region_tracker sb = new();
  bit no_idle = 0;
  bit hold_long = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.data[65:64], req_if.data[63:32], req_if.data[31:0]);
      if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("first_fit_region_allocator verification failed");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    rsp_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_long) begin
        rsp_if.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_long = 0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      @(negedge clk);
    end
  end

  task automatic send_request(logic [1:0] cmd, logic [31:0] size, logic [31:0] off);
    int gap;
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.data <= {cmd, size, off};
    do @(posedge clk); while (!req_if.ready);
    sent++;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_region(logic [31:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.region = value;
  endtask

  task automatic random_request(int alloc_pct, logic [31:0] max_size);
    logic [1:0] cmd;
    logic [31:0] size;
    logic [31:0] off;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) cmd = CMD_ALLOC;
    else if (pick < alloc_pct + (100 - alloc_pct) * 6 / 10) cmd = CMD_FREE;
    else if (pick < 98) cmd = CMD_QUERY;
    else cmd = 2'd3;
    pick = $urandom_range(0, 99);
    if (pick < 3) size = '0;
    else if (pick < 10) size = $urandom();
    else size = $urandom_range(1, max_size);
    pick = $urandom_range(0, 99);
    if (sb.count > 0 && pick < 70) off = sb.offs[$urandom_range(0, sb.count - 1)];
    else if (pick < 85) off = $urandom_range(0, 4096);
    else off = $urandom();
    send_request(cmd, size, off);
  endtask

  initial begin
    logic [31:0] regions[6];
    int pcts[6];
    logic [31:0] maxes[6];
    req_if.valid = 1'b0;
    req_if.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(CMD_QUERY, 32'd0, 32'd0);
    send_request(CMD_FREE, 32'd0, 32'd0);
    send_request(CMD_ALLOC, 32'd0, 32'd0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_request(CMD_ALLOC, 32'd65537, 32'd0);
    send_request(CMD_ALLOC, 32'd65536, 32'hFFFF_FFFF);
    send_request(CMD_ALLOC, 32'd1, 32'd0);
    send_request(CMD_QUERY, 32'hFFFF_FFFF, 32'd0);
    send_request(CMD_QUERY, 32'd0, 32'd1);
    send_request(CMD_FREE, 32'd0, 32'd0);
    send_request(CMD_ALLOC, 32'd16, 32'd0);
    send_request(CMD_ALLOC, 32'd32, 32'd0);
    send_request(CMD_ALLOC, 32'd16, 32'd0);
    send_request(CMD_FREE, 32'd0, 32'd16);
    send_request(CMD_ALLOC, 32'd8, 32'd0);
    send_request(CMD_ALLOC, 32'd24, 32'd0);
    send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 32'd0, 32'hFFFF_FFFF);
    send_request(CMD_FREE, 32'd0, 32'hFFFF_FFFF);
    write_region(32'd32);
    send_request(CMD_ALLOC, 32'd1, 32'd0);
    send_request(CMD_ALLOC, 32'd4, 32'd0);
    send_request(CMD_QUERY, 32'd0, 32'd16);

    regions = '{32'hFFFF_FFFF, 32'd4096, 32'd0, 32'd300, $urandom(), 32'd65536};
    pcts = '{85, 55, 50, 60, 55, 50};
    maxes = '{32'd1000, 32'd200, 32'd64, 32'd40, 32'h0100_0000, 32'd2048};
    for (int p = 0; p < 6; p++) begin
      write_region(regions[p]);
      if (p == 1) hold_long = 1;
      for (int i = 0; i < 255; i++) begin
        if (i == 100) no_idle = 1;
        if (i == 160) no_idle = 0;
        random_request(pcts[p], maxes[p]);
      end
    end

    wait_drained();
    repeat (300) @(posedge clk);
    $display("Sent %0d requests, checked %0d responses, %0d mismatches.",
             sent, sb.checked, sb.mismatches);
    $display("Status mix ok/oom/not-found/full/zero: %0d/%0d/%0d/%0d/%0d.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3], sb.status_seen[4]);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("first_fit_region_allocator verification clean");
    end else begin
      $display("first_fit_region_allocator verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ffra_pkg.sv
rtl/ffra_if.sv
rtl/ffra_ctrl.sv
rtl/ffra_dp.sv
rtl/first_fit_region_allocator.sv
tb/tb_first_fit_region_allocator.sv
